@@ rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Request and response types, operation and status codes, and the control
// word that the list cells share.
// ----------------------------------------------------------------------------
package ple_pkg;

   typedef enum logic [1:0] {
      OP_RETRIEVE = 2'd0,
      OP_INSERT   = 2'd1,
      OP_REMOVE   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [4:0]  position;
      logic [31:0] new_item;
   } req_type;

   typedef struct packed {
      logic [31:0] read_item;
      logic [1:0]  status;
      logic [4:0]  length;
   } rsp_type;

   // Broadcast to every cell for one accepted request.
   typedef struct packed {
      logic       shift_in;
      logic       shift_out;
      logic       read;
      logic [4:0] pos_idx;
   } cell_ctl_type;

endpackage

@@ rtl/positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of up to DEPTH items held in a row of cells, addressed by
// 1-based position, with retrieve, insert and remove requests.
// ----------------------------------------------------------------------------
//  Channel    Ports                    Direction  Transfer
//  request    start, busy, req_data    in         start high while busy low
//  response   rsp_strobe, rsp_data     out        strobe high for one cycle
//
// The cells shift in parallel at the edge that accepts a request, and the
// response appears on the following cycle. A new request may be given in
// every cycle, so busy stays low. The response is shown for exactly one
// cycle, as the receiver cannot stall. Synchronous reset empties the list;
// the cell contents are left as they are.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
   parameter int DEPTH     = 16,
   parameter int ITEM_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ple_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ple_pkg::rsp_type rsp_data
);
   import ple_pkg::*;

   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = ((LW > 5) ? LW : 5) + 1;

   logic [LW-1:0]        len_ff;
   logic [LW-1:0]        len_in;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   cell_ctl_type         ctl;
   logic                 accept;
   logic [CW-1:0]        pos_x;
   logic [CW-1:0]        len_x;
   logic                 in_list;
   logic                 ins_pos_ok;
   logic                 full;
   logic [ITEM_BITS-1:0] item_w;
   logic [ITEM_BITS-1:0] read_w;
   logic [ITEM_BITS-1:0] cell_q  [DEPTH];
   logic [ITEM_BITS-1:0] cell_rd [DEPTH];
   status_type           status;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign item_w = ITEM_BITS'(req_data.new_item);

   assign pos_x      = CW'(req_data.position);
   assign len_x      = CW'(len_ff);
   assign in_list    = (req_data.position != 5'd0) && (pos_x <= len_x);
   assign ins_pos_ok = (req_data.position != 5'd0) && (pos_x <= len_x + CW'(1));
   assign full       = (len_ff == LW'(DEPTH));

   always_comb begin
      ctl           = '0;
      ctl.pos_idx   = req_data.position - 5'd1;
      status        = ST_RANGE;
      len_in        = len_ff;
      unique case (req_data.opcode)
         OP_RETRIEVE: begin
            if (in_list) begin
               status   = ST_OK;
               ctl.read = accept;
            end
         end
         OP_INSERT: begin
            if (ins_pos_ok) begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  status       = ST_OK;
                  ctl.shift_in = accept;
                  if (accept) begin
                     len_in = len_ff + LW'(1);
                  end
               end
            end
         end
         OP_REMOVE: begin
            if (in_list) begin
               status        = ST_OK;
               ctl.shift_out = accept;
               if (accept) begin
                  len_in = len_ff - LW'(1);
               end
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ITEM_BITS-1:0] left_w;
      logic [ITEM_BITS-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = item_w;
      end else begin : g_left
         assign left_w = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_q[i];
      end else begin : g_right
         assign right_w = cell_q[i+1];
      end

      ple_cell #(
         .ITEM_BITS (ITEM_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_item   (item_w),
         .left_item  (left_w),
         .right_item (right_w),
         .item_out   (cell_q[i]),
         .read_out   (cell_rd[i])
      );
   end

   always_comb begin
      read_w = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_w = read_w | cell_rd[i];
      end
   end

   always_comb begin
      rsp_in           = rsp_ff;
      if (accept) begin
         rsp_in.read_item = 32'(read_w);
         rsp_in.status    = status;
         rsp_in.length    = 5'(len_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ rtl/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// One list slot. It loads the new item, takes its left neighbour's item on
// an insert, or takes its right neighbour's item on a remove.
// ----------------------------------------------------------------------------
module ple_cell #(
   parameter int ITEM_BITS = 32,
   parameter int INDEX     = 0
) (
   input  logic                  clock,
   input  ple_pkg::cell_ctl_type ctl,
   input  logic [ITEM_BITS-1:0]  new_item,
   input  logic [ITEM_BITS-1:0]  left_item,
   input  logic [ITEM_BITS-1:0]  right_item,
   output logic [ITEM_BITS-1:0]  item_out,
   output logic [ITEM_BITS-1:0]  read_out
);
   import ple_pkg::*;

   logic [ITEM_BITS-1:0] item_ff;
   logic [ITEM_BITS-1:0] item_in;
   logic                 at_pos;
   logic                 beyond_pos;

   assign at_pos     = (32'(INDEX) == {27'd0, ctl.pos_idx});
   assign beyond_pos = (32'(INDEX) > {27'd0, ctl.pos_idx});

   always_comb begin
      item_in = item_ff;
      priority if (ctl.shift_in) begin
         if (at_pos) begin
            item_in = new_item;
         end else if (beyond_pos) begin
            item_in = left_item;
         end
      end else if (ctl.shift_out) begin
         if (at_pos || beyond_pos) begin
            item_in = right_item;
         end
      end else begin
         item_in = item_ff;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_out = item_ff;
   assign read_out = (ctl.read && at_pos) ? item_ff : '0;

endmodule

@@ tb/sv/positional_list_engine_unit_test.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit_test
// Drives list requests into positional_list_engine_unit and checks each
// response against a local model of the list. A short directed sequence
// covers empty and full lists, bad positions and the unused opcode. It is
// followed by random requests that grow and shrink the list in turns. There
// are random gaps between requests, except in one run of back-to-back ones.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_test;
   import ple_pkg::*;

   localparam int DEPTH = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_OPS = 500;
   localparam int QUIET_FIRST = 200;
   localparam int QUIET_LAST = 300;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;

   req_type pending_ops[$];
   rsp_type awaited_results[$];
   logic [31:0] list_cells[DEPTH];
   int list_count = 0;
   int planned_length = 0;
   int sent_count = 0;
   logic taken = 1'b0;
   bit any_failure = 1'b0;

   positional_list_engine_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type res;
      int p;
      res = '0;
      res.status = ST_OK;
      p = int'(r.position);
      case (r.opcode)
         OP_RETRIEVE: begin
            if (p >= 1 && p <= list_count) res.read_item = list_cells[p - 1];
            else res.status = ST_RANGE;
         end
         OP_INSERT: begin
            if (p < 1 || p > list_count + 1) begin
               res.status = ST_RANGE;
            end else if (list_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = list_count; i >= p; i--) list_cells[i] = list_cells[i - 1];
               list_cells[p - 1] = r.new_item;
               list_count++;
            end
         end
         OP_REMOVE: begin
            if (p >= 1 && p <= list_count) begin
               for (int i = p; i < list_count; i++) list_cells[i - 1] = list_cells[i];
               list_count--;
            end else begin
               res.status = ST_RANGE;
            end
         end
         default: res.status = ST_RANGE;
      endcase
      res.length = 5'(list_count);
      return res;
   endfunction

   // Queues a request and keeps track of the length the list will have, so
   // that later positions can be aimed at the valid range.
   task automatic queue_op(input logic [1:0] op, input int pos, input logic [31:0] item);
      req_type r;
      r.opcode = op;
      r.position = 5'(pos);
      r.new_item = item;
      pending_ops.push_back(r);
      if (op == OP_INSERT && pos >= 1 && pos <= planned_length + 1 && planned_length < DEPTH)
         planned_length++;
      else if (op == OP_REMOVE && pos >= 1 && pos <= planned_length)
         planned_length--;
   endtask

   function automatic logic [31:0] pick_item();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return ALL_ONES;
      return $urandom;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (pending_ops.size() != 0 &&
             !((sent_count < QUIET_FIRST || sent_count >= QUIET_LAST) &&
               $urandom_range(99) < 25)) begin
            req_data <= pending_ops.pop_front();
            start <= 1'b1;
            sent_count <= sent_count + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected response %h", rsp_data);
               any_failure = 1'b1;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.read_item !== want.read_item) begin
                  $error("read_item: expected %h, got %h", want.read_item, rsp_data.read_item);
                  any_failure = 1'b1;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  any_failure = 1'b1;
               end
               if (rsp_data.length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_data.length);
                  any_failure = 1'b1;
               end
            end
         end
         taken <= start && !busy;
         if (start && !busy) awaited_results.push_back(apply_list_op(req_data));
      end
   end

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      bit growing;
      int run_left;
      int unsigned r;
      logic [1:0] op;

      // Operations on an empty list, then a short list built at front,
      // back and middle.
      queue_op(OP_RETRIEVE, 1, '0);
      queue_op(OP_REMOVE, 0, '0);
      queue_op(OP_INSERT, 0, 32'h1234_5678);
      queue_op(OP_INSERT, 2, 32'h1111_1111);
      queue_op(OP_INSERT, 1, ALL_ONES);
      queue_op(OP_INSERT, 1, '0);
      queue_op(OP_INSERT, 3, 32'hA5A5_A5A5);
      queue_op(OP_INSERT, 2, 32'h5A5A_5A5A);
      queue_op(OP_RETRIEVE, 4, ALL_ONES);
      queue_op(OP_RETRIEVE, 5, '0);
      queue_op(OP_UNUSED, 1, ALL_ONES);
      queue_op(OP_REMOVE, 2, '0);
      queue_op(OP_REMOVE, 3, '0);
      // Fill the list, then try a full insert and the edges of the range.
      while (planned_length < DEPTH)
         queue_op(OP_INSERT, $urandom_range(planned_length + 1, 1), pick_item());
      queue_op(OP_INSERT, 1, 32'hDEAD_BEEF);
      queue_op(OP_INSERT, DEPTH + 1, 32'hDEAD_BEEF);
      queue_op(OP_INSERT, 31, ALL_ONES);
      queue_op(OP_RETRIEVE, DEPTH, '0);
      queue_op(OP_REMOVE, 31, '0);
      queue_op(OP_REMOVE, DEPTH, '0);
      queue_op(OP_REMOVE, 1, '0);

      // The list drifts between empty and full so that both ends are met
      // often; a small share of requests is arbitrary.
      growing = 1'b0;
      run_left = 0;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (run_left == 0) begin
            growing = !growing;
            run_left = $urandom_range(60, 20);
         end
         run_left--;
         r = $urandom_range(99);
         if (r < 8) begin
            queue_op(2'($urandom_range(3)), $urandom_range(31), $urandom);
         end else begin
            r = $urandom_range(99);
            if (r < 25) op = OP_RETRIEVE;
            else if (r < 85) op = growing ? OP_INSERT : OP_REMOVE;
            else op = growing ? OP_REMOVE : OP_INSERT;
            if (op == OP_INSERT)
               queue_op(op, $urandom_range(planned_length + 1, 1), pick_item());
            else
               queue_op(op, $urandom_range(planned_length > 0 ? planned_length : 1, 1),
                        pick_item());
         end
      end

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_ops.size() != 0 || start || awaited_results.size() != 0);
      repeat (4) @(negedge clock);

      if (!any_failure && awaited_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
